// ===== src/btdd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btdd_pkg
// Shared types, constants and the double-dabble step for the decimal digit
// display converter.
// ----------------------------------------------------------------------------
package btdd_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int DAB_STEPS  = 8;
    localparam int DAB_STAGES = VALUE_W / DAB_STEPS;

    localparam logic [3:0] BLANK_CODE = 4'd10;

    localparam int CFG_ADDR_W = 4;

    localparam logic [1:0] REG_DIGIT_COUNT   = 2'd0;
    localparam logic [1:0] REG_RIGHT_JUSTIFY = 2'd1;
    localparam logic [1:0] REG_ZERO_FILL     = 2'd2;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } dab_t;

    function automatic dab_t dab_step(input dab_t d);
        dab_t r;
        r = d;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r.bcd[4*i +: 4] >= 4'd5) begin
                r.bcd[4*i +: 4] = r.bcd[4*i +: 4] + 4'd3;
            end
        end
        r = dab_t'({r.bcd, r.bin} << 1);
        return r;
    endfunction

endpackage

// ===== src/btdd_dabble.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btdd_dabble
// One pipeline slice of the binary to BCD conversion: several shift and
// add-three steps followed by a register, with a valid/ready handshake.
// ----------------------------------------------------------------------------
module btdd_dabble (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire btdd_pkg::dab_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output btdd_pkg::dab_t     out_data
);
    import btdd_pkg::*;

    logic vld_reg;
    dab_t data_reg;
    dab_t data_next;

    always_comb begin
        data_next = in_data;
        for (int s = 0; s < DAB_STEPS; s++) begin
            data_next = dab_step(data_next);
        end
    end

    assign in_ready  = !vld_reg || out_ready;
    assign out_valid = vld_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (in_ready) begin
            vld_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/binary_to_decimal_digit_display.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_digit_display
// Converts a 32-bit unsigned value into one digit request per display
// position, with left/right justification and leading-zero blanking or zero fill.
// ----------------------------------------------------------------------------
// Each accepted value yields one output request per position in use
// (digit_count, clamped to 1..MAX_DIGITS), leftmost position first, with
// tlast on the final one. The output serializer emits one position per
// cycle while m_tready does not hold it back, and values stream back to
// back; on its way from an accepted input request, a value passes through
// four conversion slices, the serializer load and the output register
// before its first output request is presented.
// ----------------------------------------------------------------------------
module binary_to_decimal_digit_display #(
    parameter int MAX_DIGITS = 10
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [3:0] position, [7:4] digit_code
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [btdd_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import btdd_pkg::*;

    // configuration
    logic [3:0] dc_reg;
    logic       rj_reg;
    logic       zf_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dc_reg <= 4'd10;
            rj_reg <= 1'b1;
            zf_reg <= 1'b0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_DIGIT_COUNT:   dc_reg <= pwdata[3:0];
                REG_RIGHT_JUSTIFY: rj_reg <= pwdata[0];
                REG_ZERO_FILL:     zf_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DIGIT_COUNT:   prdata = {28'd0, dc_reg};
            REG_RIGHT_JUSTIFY: prdata = {31'd0, rj_reg};
            REG_ZERO_FILL:     prdata = {31'd0, zf_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // conversion pipeline
    logic chain_vld [DAB_STAGES+1];
    logic chain_rdy [DAB_STAGES+1];
    dab_t chain_data [DAB_STAGES+1];

    assign chain_vld[0]      = s_tvalid;
    assign chain_data[0].bcd = '0;
    assign chain_data[0].bin = s_tdata;
    assign s_tready          = chain_rdy[0];

    for (genvar g = 0; g < DAB_STAGES; g++) begin : g_dab
        btdd_dabble u_dab (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_vld[g]),
            .in_ready  (chain_rdy[g]),
            .in_data   (chain_data[g]),
            .out_valid (chain_vld[g+1]),
            .out_ready (chain_rdy[g+1]),
            .out_data  (chain_data[g+1])
        );
    end

    // serializer
    logic       ser_busy_reg;
    logic [3:0] ser_pos_reg;
    logic [3:0] ser_last_reg;
    logic [3:0] ser_top_reg;
    logic       ser_rj_reg;
    logic       ser_zf_reg;
    logic [3:0] ser_dig_reg [MAX_DIGITS];

    logic [3:0] n_used;
    logic [3:0] last_next;
    logic [3:0] top_next;
    logic       emit;
    logic       load_ok;
    logic       load;
    logic [3:0] idx;
    logic       blank;
    logic [3:0] code_next;

    logic       m_tvalid_reg;
    logic [3:0] m_pos_reg;
    logic [3:0] m_code_reg;
    logic       m_last_reg;

    always_comb begin
        if (dc_reg == 4'd0) begin
            n_used = 4'd1;
        end else if (dc_reg > 4'(MAX_DIGITS)) begin
            n_used = 4'(MAX_DIGITS);
        end else begin
            n_used = dc_reg;
        end
        last_next = n_used - 4'd1;
        top_next  = 4'd0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (4'(i) < n_used && chain_data[DAB_STAGES].bcd[4*i +: 4] != 4'd0) begin
                top_next = 4'(i);
            end
        end
    end

    assign emit    = ser_busy_reg && (!m_tvalid_reg || m_tready);
    assign load_ok = !ser_busy_reg || (emit && ser_pos_reg == ser_last_reg);
    assign load    = load_ok && chain_vld[DAB_STAGES];
    assign chain_rdy[DAB_STAGES] = load_ok;

    always_comb begin
        if (!ser_rj_reg) begin
            blank = ser_pos_reg > ser_top_reg;
            idx   = ser_top_reg - ser_pos_reg;
        end else if (ser_zf_reg) begin
            blank = 1'b0;
            idx   = ser_last_reg - ser_pos_reg;
        end else begin
            blank = ser_pos_reg < (ser_last_reg - ser_top_reg);
            idx   = ser_last_reg - ser_pos_reg;
        end
        code_next = BLANK_CODE;
        if (!blank) begin
            code_next = 4'd0;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                if (idx == 4'(i)) begin
                    code_next = ser_dig_reg[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ser_busy_reg <= 1'b0;
            ser_pos_reg  <= 4'd0;
        end else if (load) begin
            ser_busy_reg <= 1'b1;
            ser_pos_reg  <= 4'd0;
        end else if (emit) begin
            if (ser_pos_reg == ser_last_reg) begin
                ser_busy_reg <= 1'b0;
            end
            ser_pos_reg <= ser_pos_reg + 4'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ser_last_reg <= last_next;
            ser_top_reg  <= top_next;
            ser_rj_reg   <= rj_reg;
            ser_zf_reg   <= zf_reg;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                ser_dig_reg[i] <= chain_data[DAB_STAGES].bcd[4*i +: 4];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_pos_reg  <= ser_pos_reg;
            m_code_reg <= code_next;
            m_last_reg <= (ser_pos_reg == ser_last_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_code_reg, m_pos_reg};
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ser_busy_reg |-> ser_pos_reg <= ser_last_reg)
        else $error("serializer position past last");

    a_emit_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_tvalid_reg && m_pos_reg == $past(ser_pos_reg))
        else $error("emitted position not in output register");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg |-> m_code_reg <= BLANK_CODE)
        else $error("digit code out of range");

    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && m_last_reg) |-> m_pos_reg < 4'(MAX_DIGITS))
        else $error("last position beyond display");
`endif

endmodule
`default_nettype wire
